### hdl/aprq_pkg.sv
// ----------------------------------------------------------------------------
// aprq_pkg: shared types and constants of the aging priority ready queue
// Widths, opcodes, status codes, controller states and the table command.
// ----------------------------------------------------------------------------
`default_nettype none

package aprq_pkg;

   localparam int MAX_TASKS    = 16;
   localparam int ID_W         = 4;
   localparam int POS_W        = $clog2(MAX_TASKS);
   localparam int COUNT_W      = $clog2(MAX_TASKS + 1);
   localparam int PRIO_W       = 6;
   localparam int REQ_PRIO_W   = 8;
   localparam int FUNC_W       = 3;
   localparam int STATUS_W     = 2;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 16;
   localparam int ID_SPACE     = (MAX_TASKS < (1 << ID_W)) ? MAX_TASKS : (1 << ID_W);
   localparam int FIRST_USER_ID = 2;

   typedef logic [ID_W-1:0]          id_type;
   typedef logic signed [PRIO_W-1:0] prio_type;

   localparam prio_type PRIO_LOW  = prio_type'(-20);
   localparam prio_type PRIO_ZERO = prio_type'(0);
   localparam logic signed [REQ_PRIO_W-1:0] REQ_LOW  = REQ_PRIO_W'(-20);
   localparam logic signed [REQ_PRIO_W-1:0] REQ_HIGH = REQ_PRIO_W'(20);

   typedef enum logic [FUNC_W-1:0] {
      FN_CREATE   = 3'd0,
      FN_APPEND   = 3'd1,
      FN_SET_PRIO = 3'd2,
      FN_DISPATCH = 3'd3,
      FN_GET_PRIO = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REMOVE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD
   } cell_op_type;

   // Priority table command: one write or one dispatch update per cycle
   typedef struct packed {
      logic     wr_en;
      logic     age_en;
      id_type   addr;
      prio_type value;
   } tbl_cmd_type;

endpackage

`default_nettype wire

### hdl/aging_priority_ready_queue_unit.sv
// ----------------------------------------------------------------------------
// aging_priority_ready_queue_unit: ready queue with aging priority dispatch
// Task ids in arrival order, static and dynamic priorities, create / append /
// set priority / dispatch / get priority, one response word per request word.
// ----------------------------------------------------------------------------
// Usage: send one request word (req_tuser = function code, req_tdata = task
// id and requested priority); exactly one response word comes back with the
// task id, the static priority and a status in rsp_tuser. Create, append,
// set priority, get priority and unused codes finish in the accept cycle;
// their response sits in the output register on the next cycle and a new
// request is taken as soon as that response is (or is being) consumed.
// Dispatch holds the unit through a scan state and a remove state: the
// queue is a row of 16 cells that rotates one slot per cycle past a single
// comparator at the head cell until a full turn restores the original
// order, then the remove state, once the output register is free, removes
// the winner by shifting the cells behind it left, ages all remaining
// queued tasks in parallel and writes the response. A dispatch on an empty
// queue answers at once with status empty. Lower priority numbers are more
// urgent; ties go to the lower static priority, then to the earlier
// arrival. Priorities reset to 0, created ids start at 2 and run out after 15.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_priority_ready_queue_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request word
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [aprq_pkg::REQ_DATA_W-1:0]    req_tdata,  // [3:0] task_id, [11:4] prio
   input  wire logic [aprq_pkg::FUNC_W-1:0]        req_tuser,  // [2:0] func
   // response word
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [aprq_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // [3:0] out_task_id, [9:4] out_prio
   output logic [aprq_pkg::STATUS_W-1:0]           rsp_tuser   // [1:0] status
);
   import aprq_pkg::*;

   localparam logic [POS_W-1:0] LAST_STEP = POS_W'(MAX_TASKS - 1);

   // ---- request fields ----
   id_type                         req_id;
   logic signed [REQ_PRIO_W-1:0]   req_prio;
   func_type                       req_func;

   assign req_id   = req_tdata[ID_W-1:0];
   assign req_prio = $signed(req_tdata[ID_W+REQ_PRIO_W-1:ID_W]);
   assign req_func = func_type'(req_tuser);

   // ---- control state ----
   state_type              state_ff, state_in;
   logic [POS_W-1:0]       step_ff, step_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     next_id_ff, next_id_in;
   logic [MAX_TASKS-1:0]   inq_ff, inq_in;

   // best candidate found so far during the scan
   logic                   best_valid_ff, best_valid_in;
   logic [POS_W-1:0]       best_pos_ff, best_pos_in;
   id_type                 best_id_ff, best_id_in;
   prio_type               best_dyn_ff, best_dyn_in;
   prio_type               best_st_ff, best_st_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   id_type                 rsp_id_ff, rsp_id_in;
   prio_type               rsp_prio_ff, rsp_prio_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   out_free;

   // ---- cell row ----
   id_type                 cell_id  [MAX_TASKS];
   id_type                 nbr_id   [MAX_TASKS];
   cell_op_type            cell_op  [MAX_TASKS];
   id_type                 load_id;

   // ---- priority table ----
   tbl_cmd_type            tbl_cmd;
   id_type                 rd_addr;
   prio_type               rd_static;
   prio_type               rd_dynamic;

   // helpers
   id_type                 head_id;
   logic                   head_live;
   logic                   head_better;
   prio_type               set_value;
   id_type                 new_id;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign head_id  = cell_id[0];
   assign rd_addr  = (state_ff == S_SCAN) ? head_id : req_id;
   assign new_id   = next_id_ff[ID_W-1:0];

   // head cell holds queue entry step_ff during the scan
   assign head_live   = {1'b0, step_ff} < count_ff;
   assign head_better = head_live &&
                        (!best_valid_ff || rd_dynamic < best_dyn_ff ||
                         (rd_dynamic == best_dyn_ff && rd_static < best_st_ff));

   assign set_value = (req_prio >= REQ_LOW && req_prio <= REQ_HIGH) ?
                      prio_type'(req_prio) : PRIO_ZERO;

   // ---- cells, each fed by its right neighbor (ring) ----
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      assign nbr_id[i] = cell_id[(i + 1) % MAX_TASKS];

      aprq_cell u_cell (
         .clock   (clock),
         .op      (cell_op[i]),
         .nbr_id  (nbr_id[i]),
         .load_id (load_id),
         .id_q    (cell_id[i])
      );
   end

   aprq_prio_table u_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tbl_cmd),
      .age_mask   (inq_in),
      .rd_addr    (rd_addr),
      .rd_static  (rd_static),
      .rd_dynamic (rd_dynamic)
   );

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_func == FN_DISPATCH && count_ff != '0) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (step_ff == LAST_STEP) begin
               state_in = S_REMOVE;
            end
         end
         S_REMOVE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---- datapath control ----
   always_comb begin
      step_in       = step_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      inq_in        = inq_ff;
      best_valid_in = best_valid_ff;
      best_pos_in   = best_pos_ff;
      best_id_in    = best_id_ff;
      best_dyn_in   = best_dyn_ff;
      best_st_in    = best_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_status_in = rsp_status_ff;
      load_id       = req_id;
      tbl_cmd       = '{wr_en: 1'b0, age_en: 1'b0, addr: req_id, value: PRIO_ZERO};
      for (int i = 0; i < MAX_TASKS; i++) begin
         cell_op[i] = CELL_HOLD;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = req_id;
               rsp_prio_in   = PRIO_ZERO;
               rsp_status_in = STAT_OK;
               case (req_func)
                  FN_CREATE: begin
                     if (next_id_ff >= COUNT_W'(ID_SPACE) ||
                         count_ff >= COUNT_W'(MAX_TASKS)) begin
                        rsp_id_in     = '0;
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_id_in     = new_id;
                        tbl_cmd.wr_en = 1'b1;
                        tbl_cmd.addr  = new_id;
                        next_id_in    = next_id_ff + COUNT_W'(1);
                        load_id       = new_id;
                        // an id appended before it was created stays put
                        if (!inq_ff[new_id]) begin
                           inq_in[new_id] = 1'b1;
                           count_in       = count_ff + COUNT_W'(1);
                           for (int i = 0; i < MAX_TASKS; i++) begin
                              if (count_ff == COUNT_W'(i)) cell_op[i] = CELL_LOAD;
                           end
                        end
                     end
                  end
                  FN_APPEND: begin
                     if ({1'b0, req_id} >= COUNT_W'(MAX_TASKS)) begin
                        rsp_status_in = STAT_IGNORED;
                     end else begin
                        rsp_prio_in = rd_static;
                        if (req_id == '0 || inq_ff[req_id]) begin
                           rsp_status_in = STAT_IGNORED;
                        end else if (count_ff >= COUNT_W'(MAX_TASKS)) begin
                           rsp_status_in = STAT_FULL;
                        end else begin
                           inq_in[req_id] = 1'b1;
                           count_in       = count_ff + COUNT_W'(1);
                           for (int i = 0; i < MAX_TASKS; i++) begin
                              if (count_ff == COUNT_W'(i)) cell_op[i] = CELL_LOAD;
                           end
                        end
                     end
                  end
                  FN_SET_PRIO: begin
                     if ({1'b0, req_id} >= COUNT_W'(MAX_TASKS)) begin
                        rsp_status_in = STAT_IGNORED;
                     end else begin
                        tbl_cmd.wr_en = 1'b1;
                        tbl_cmd.value = set_value;
                        rsp_prio_in   = set_value;
                     end
                  end
                  FN_DISPATCH: begin
                     if (count_ff == '0) begin
                        rsp_id_in     = '0;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        // response comes from the remove cycle
                        rsp_valid_in  = 1'b0;
                        best_valid_in = 1'b0;
                        step_in       = '0;
                     end
                  end
                  FN_GET_PRIO: begin
                     if ({1'b0, req_id} >= COUNT_W'(MAX_TASKS)) begin
                        rsp_status_in = STAT_IGNORED;
                     end else begin
                        rsp_prio_in = rd_static;
                     end
                  end
                  default: begin
                     rsp_id_in     = '0;
                     rsp_status_in = STAT_IGNORED;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // rotate one slot; the comparator looks at the head cell
            for (int i = 0; i < MAX_TASKS; i++) begin
               cell_op[i] = CELL_SHIFT;
            end
            step_in = step_ff + POS_W'(1);
            if (head_better) begin
               best_valid_in = 1'b1;
               best_pos_in   = step_ff;
               best_id_in    = head_id;
               best_dyn_in   = rd_dynamic;
               best_st_in    = rd_static;
            end
         end

         S_REMOVE: begin
            if (out_free) begin
               // close the gap left by the winner
               for (int i = 0; i < MAX_TASKS; i++) begin
                  if (POS_W'(i) >= best_pos_ff) cell_op[i] = CELL_SHIFT;
               end
               inq_in[best_id_ff] = 1'b0;
               count_in           = count_ff - COUNT_W'(1);
               tbl_cmd.age_en     = 1'b1;
               tbl_cmd.addr       = best_id_ff;
               rsp_valid_in       = 1'b1;
               rsp_id_in          = best_id_ff;
               rsp_prio_in        = best_st_ff;
               rsp_status_in      = STAT_OK;
            end
         end

         default: ;
      endcase
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         count_ff      <= '0;
         next_id_ff    <= COUNT_W'(FIRST_USER_ID);
         inq_ff        <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
         next_id_ff    <= next_id_in;
         inq_ff        <= inq_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_pos_ff   <= best_pos_in;
      best_id_ff    <= best_id_in;
      best_dyn_ff   <= best_dyn_in;
      best_st_ff    <= best_st_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-ID_W-PRIO_W){1'b0}}, rsp_prio_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ---- assertions ----
   // queue fill always matches the number of queued-task flags
   a_count_flags: assert property (@(posedge clock) disable iff (reset)
      $countones(inq_ff) == count_ff)
      else $error("queue count and queued flags disagree");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_TASKS))
      else $error("queue count overflow");

   // a finished scan always has a winner
   a_scan_winner: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REMOVE |-> best_valid_ff && inq_ff[best_id_ff])
      else $error("remove without a queued winner");

   // the remove cycle delivers an ok response and drops one entry
   a_remove_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REMOVE && out_free) |=>
         (rsp_valid_ff && rsp_status_ff == STAT_OK &&
          count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("dispatch response or removal missing");

endmodule

`default_nettype wire

### hdl/aprq_cell.sv
// ----------------------------------------------------------------------------
// aprq_cell: one slot of the ready queue
// Holds a task id; keeps it, takes the right neighbor's id, or loads a new one.
// ----------------------------------------------------------------------------
`default_nettype none

module aprq_cell (
   input  wire logic                 clock,
   input  wire aprq_pkg::cell_op_type op,
   input  wire aprq_pkg::id_type     nbr_id,
   input  wire aprq_pkg::id_type     load_id,
   output aprq_pkg::id_type          id_q
);
   import aprq_pkg::*;

   id_type id_ff;
   id_type id_in;

   always_comb begin
      case (op)
         CELL_SHIFT: id_in = nbr_id;
         CELL_LOAD:  id_in = load_id;
         default:    id_in = id_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id_q = id_ff;

endmodule

`default_nettype wire

### hdl/aprq_prio_table.sv
// ----------------------------------------------------------------------------
// aprq_prio_table: static and dynamic priority of every task
// One read port; writes for set priority / create; dispatch reload and aging.
// ----------------------------------------------------------------------------
`default_nettype none

module aprq_prio_table (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire aprq_pkg::tbl_cmd_type  cmd,
   input  wire logic [aprq_pkg::MAX_TASKS-1:0] age_mask,
   input  wire aprq_pkg::id_type       rd_addr,
   output aprq_pkg::prio_type          rd_static,
   output aprq_pkg::prio_type          rd_dynamic
);
   import aprq_pkg::*;

   prio_type static_ff  [MAX_TASKS];
   prio_type static_in  [MAX_TASKS];
   prio_type dynamic_ff [MAX_TASKS];
   prio_type dynamic_in [MAX_TASKS];

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         static_in[i]  = static_ff[i];
         dynamic_in[i] = dynamic_ff[i];
         if (cmd.wr_en && cmd.addr == ID_W'(i)) begin
            static_in[i]  = cmd.value;
            dynamic_in[i] = cmd.value;
         end else if (cmd.age_en) begin
            if (cmd.addr == ID_W'(i)) begin
               // dispatched task restarts from its static priority
               dynamic_in[i] = static_ff[i];
            end else if (age_mask[i]) begin
               dynamic_in[i] = (dynamic_ff[i] > PRIO_LOW) ?
                               dynamic_ff[i] - prio_type'(1) : PRIO_LOW;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (reset) begin
            static_ff[i]  <= PRIO_ZERO;
            dynamic_ff[i] <= PRIO_ZERO;
         end else begin
            static_ff[i]  <= static_in[i];
            dynamic_ff[i] <= dynamic_in[i];
         end
      end
   end

   assign rd_static  = static_ff[rd_addr];
   assign rd_dynamic = dynamic_ff[rd_addr];

endmodule

`default_nettype wire
